// File: sv/svm_dt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dt_pkg
// Shared types and constants of the linear SVM decision tree classifier.
// ----------------------------------------------------------------------------
package svm_dt_pkg;

   localparam int TABLE_DEPTH   = 16;
   localparam int IDX_W         = 4;
   localparam int SLOT_W        = 3;
   localparam int WORD_W        = 16;
   localparam int CLASS_W       = 8;
   localparam int LANES         = 3;
   localparam int PROD_W        = 2 * WORD_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int DEC_W         = 40;
   localparam int NODES_DEFAULT = 16;

   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_BIAS   = 3'd0,
      SLOT_W0     = 3'd1,
      SLOT_W1     = 3'd2,
      SLOT_W2     = 3'd3,
      SLOT_CLS0   = 3'd4,
      SLOT_CLS1   = 3'd5,
      SLOT_CHILD0 = 3'd6,
      SLOT_CHILD1 = 3'd7
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_MERGE
   } state_type;

   typedef struct packed {
      logic [1:0][IDX_W-1:0]   child;
      logic [1:0][CLASS_W-1:0] cls;
      logic [LANES-1:0][WORD_W-1:0] weight;
      logic [WORD_W-1:0]       bias;
   } node_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  node;
      slot_type          slot;
      logic [WORD_W-1:0] value;
   } wr_type;

   typedef logic [LANES-1:0][PROD_W-1:0] prod_arr_type;

endpackage

// File: sv/svm_dt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dt_table
// Node table: word-wise write port, one read port at the current node.
// ----------------------------------------------------------------------------
module svm_dt_table (
   input  logic                          clock,
   input  logic                          reset,
   input  svm_dt_pkg::wr_type            wr,
   input  logic [svm_dt_pkg::IDX_W-1:0]  rd_idx,
   output svm_dt_pkg::node_type          rd_node
);

   svm_dt_pkg::node_type table_ff [svm_dt_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < svm_dt_pkg::TABLE_DEPTH; i++) begin
            table_ff[i] <= '0;
         end
      end else if (wr.en) begin
         case (wr.slot)
            svm_dt_pkg::SLOT_BIAS:   table_ff[wr.node].bias      <= wr.value;
            svm_dt_pkg::SLOT_W0:     table_ff[wr.node].weight[0] <= wr.value;
            svm_dt_pkg::SLOT_W1:     table_ff[wr.node].weight[1] <= wr.value;
            svm_dt_pkg::SLOT_W2:     table_ff[wr.node].weight[2] <= wr.value;
            svm_dt_pkg::SLOT_CLS0:
               table_ff[wr.node].cls[0] <= wr.value[svm_dt_pkg::CLASS_W-1:0];
            svm_dt_pkg::SLOT_CLS1:
               table_ff[wr.node].cls[1] <= wr.value[svm_dt_pkg::CLASS_W-1:0];
            svm_dt_pkg::SLOT_CHILD0:
               table_ff[wr.node].child[0] <= wr.value[svm_dt_pkg::IDX_W-1:0];
            svm_dt_pkg::SLOT_CHILD1:
               table_ff[wr.node].child[1] <= wr.value[svm_dt_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   assign rd_node = table_ff[rd_idx];

endmodule

// File: sv/svm_dt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dt_lane
// One band lane: registered signed band times weight product.
// ----------------------------------------------------------------------------
module svm_dt_lane (
   input  logic                                  clock,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  band,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  weight,
   output logic signed [svm_dt_pkg::PROD_W-1:0]  product_ff
);

   logic signed [svm_dt_pkg::PROD_W-1:0] product_in;

   assign product_in = band * weight;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// File: sv/svm_dt_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dt_merge
// Merges lane products: sum*50 + bias*65535, side taken from the sign.
// ----------------------------------------------------------------------------
module svm_dt_merge (
   input  svm_dt_pkg::prod_arr_type            product,
   input  logic [svm_dt_pkg::WORD_W-1:0]       bias,
   output logic                                side
);

   localparam int DW = svm_dt_pkg::DEC_W;

   logic signed [svm_dt_pkg::SUM_W-1:0] sum;
   logic signed [DW-1:0]                sum_x;
   logic signed [DW-1:0]                bias_x;
   logic signed [DW-1:0]                scaled;
   logic signed [DW-1:0]                bias_term;
   logic signed [DW-1:0]                decision;

   always_comb begin
      sum = '0;
      for (int i = 0; i < svm_dt_pkg::LANES; i++) begin
         sum = sum + svm_dt_pkg::SUM_W'($signed(product[i]));
      end
      sum_x     = DW'(sum);
      bias_x    = DW'($signed(bias));
      // times 50 = 32 + 16 + 2, times 65535 = 65536 - 1
      scaled    = (sum_x <<< 5) + (sum_x <<< 4) + (sum_x <<< 1);
      bias_term = (bias_x <<< 16) - bias_x;
      decision  = scaled + bias_term;
      side      = ~decision[DW-1];
   end

endmodule

// File: sv/svm_decision_tree_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_decision_tree_classifier
// Walks a 16-node table of linear SVM nodes for each three-band pixel.
// ----------------------------------------------------------------------------
// each node visit runs the ST_MULT state, in which the lane products are registered,
//   then the ST_MERGE state; rsp_valid strobes after V = 1 .. NODES visits
// a new pixel or node write is taken only while idle, never during a walk
// start is taken again in the cycle the result is shown; no output stall
// reset clears the node table to zero and returns control to idle
// ----------------------------------------------------------------------------
module svm_decision_tree_classifier #(
   parameter int NODES = svm_dt_pkg::NODES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_cmd,
   input  logic [svm_dt_pkg::IDX_W-1:0]          req_node,
   input  logic [svm_dt_pkg::SLOT_W-1:0]         req_slot,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  req_value,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  req_band_0,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  req_band_1,
   input  logic signed [svm_dt_pkg::WORD_W-1:0]  req_band_2,
   output logic                                  rsp_valid,
   output logic [svm_dt_pkg::CLASS_W-1:0]        rsp_label,
   output logic                                  rsp_loop_error
);

   localparam int VISIT_W = $clog2(NODES);
   localparam logic [VISIT_W-1:0] VISIT_LAST = VISIT_W'(NODES - 1);

   svm_dt_pkg::state_type state_ff, state_in;
   logic [svm_dt_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [VISIT_W-1:0]            visit_ff, visit_in;
   logic [svm_dt_pkg::LANES-1:0][svm_dt_pkg::WORD_W-1:0] band_ff, band_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [svm_dt_pkg::CLASS_W-1:0] rsp_label_ff, rsp_label_in;
   logic                          rsp_loop_error_ff, rsp_loop_error_in;

   svm_dt_pkg::wr_type            wr;
   svm_dt_pkg::node_type          cur_node;
   svm_dt_pkg::prod_arr_type      product;
   logic                          side;
   logic [svm_dt_pkg::IDX_W-1:0]  next_idx;
   logic                          accept;

   assign busy   = (state_ff != svm_dt_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign wr.en    = accept && (req_cmd == svm_dt_pkg::CMD_WRITE);
   assign wr.node  = req_node;
   assign wr.slot  = svm_dt_pkg::slot_type'(req_slot);
   assign wr.value = req_value;

   svm_dt_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_idx  (idx_ff),
      .rd_node (cur_node)
   );

   for (genvar g = 0; g < svm_dt_pkg::LANES; g++) begin : g_lane
      svm_dt_lane u_lane (
         .clock      (clock),
         .band       ($signed(band_ff[g])),
         .weight     ($signed(cur_node.weight[g])),
         .product_ff (product[g])
      );
   end

   svm_dt_merge u_merge (
      .product (product),
      .bias    (cur_node.bias),
      .side    (side)
   );

   assign next_idx = cur_node.child[side];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svm_dt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff            <= idx_in;
      visit_ff          <= visit_in;
      band_ff           <= band_in;
      rsp_label_ff      <= rsp_label_in;
      rsp_loop_error_ff <= rsp_loop_error_in;
   end

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      visit_in          = visit_ff;
      band_in           = band_ff;
      rsp_valid_in      = 1'b0;
      rsp_label_in      = rsp_label_ff;
      rsp_loop_error_in = rsp_loop_error_ff;
      case (state_ff)
         svm_dt_pkg::ST_IDLE: begin
            if (accept && (req_cmd == svm_dt_pkg::CMD_CLASSIFY)) begin
               band_in  = {req_band_2, req_band_1, req_band_0};
               idx_in   = '0;
               visit_in = '0;
               state_in = svm_dt_pkg::ST_MULT;
            end
         end
         svm_dt_pkg::ST_MULT: begin
            state_in = svm_dt_pkg::ST_MERGE;
         end
         svm_dt_pkg::ST_MERGE: begin
            if (next_idx == '0) begin
               rsp_valid_in      = 1'b1;
               rsp_label_in      = cur_node.cls[side];
               rsp_loop_error_in = 1'b0;
               state_in          = svm_dt_pkg::ST_IDLE;
            end else if (visit_ff == VISIT_LAST) begin
               rsp_valid_in      = 1'b1;
               rsp_label_in      = '0;
               rsp_loop_error_in = 1'b1;
               state_in          = svm_dt_pkg::ST_IDLE;
            end else begin
               idx_in   = next_idx;
               visit_in = visit_ff + 1'b1;
               state_in = svm_dt_pkg::ST_MULT;
            end
         end
         default: begin
            state_in = svm_dt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_label      = rsp_label_ff;
   assign rsp_loop_error = rsp_loop_error_ff;

   a_rsp_after_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == svm_dt_pkg::ST_MERGE))
      else $error("result strobe without a merge cycle");

   a_mult_to_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == svm_dt_pkg::ST_MULT) |=> (state_ff == svm_dt_pkg::ST_MERGE))
      else $error("multiply cycle not followed by merge");

   a_loop_label_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_loop_error_ff) |-> (rsp_label_ff == '0))
      else $error("loop result with nonzero label");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result shown while a walk is still running");

endmodule
